// ===== sv/particle_energy_distance_histogram_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the particle energy distance histogram
// Shared property templates used by the port checker.
// ----------------------------------------------------------------------------
`ifndef PARTICLE_ENERGY_DISTANCE_HISTOGRAM_DEFINES_SVH
`define PARTICLE_ENERGY_DISTANCE_HISTOGRAM_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEDH_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pedh port check failed");

// Consequent must hold in the cycle after the antecedent.
`define PEDH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pedh port check failed");

`endif

// ===== sv/pedh_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle energy distance histogram package
// Shared types, codes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package pedh_pkg;

    localparam logic [1:0] OP_RECORD     = 2'd0;
    localparam logic [1:0] OP_READ       = 2'd1;
    localparam logic [1:0] OP_READ_CLEAR = 2'd2;

    localparam logic [2:0] REG_ENERGY_MIN       = 3'd0;
    localparam logic [2:0] REG_ENERGY_MAX       = 3'd1;
    localparam logic [2:0] REG_ENERGY_SCALE     = 3'd2;
    localparam logic [2:0] REG_DIST_MAX         = 3'd3;
    localparam logic [2:0] REG_DIST_SCALE       = 3'd4;
    localparam logic [2:0] REG_ENERGY_BINS_USED = 3'd5;
    localparam logic [2:0] REG_DIST_BINS_USED   = 3'd6;

    localparam logic [31:0] ID_PHOTON   = 32'd22;
    localparam logic [31:0] ID_ELECTRON = 32'd11;
    localparam logic [31:0] ID_POSITRON = 32'hFFFF_FFF5;

    typedef enum logic [2:0] {
        ST_COUNTED      = 3'd0,
        ST_UNTRACKED    = 3'd1,
        ST_ENERGY_RANGE = 3'd2,
        ST_TOO_FAR      = 3'd3,
        ST_READ_DONE    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        LANE_PHOTON   = 2'd0,
        LANE_ELECTRON = 2'd1,
        LANE_POSITRON = 2'd2
    } t_lane;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_MOD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [15:0] energy_min;
        logic [15:0] energy_max;
        logic [23:0] energy_scale;
        logic [31:0] dist_max;
        logic [31:0] dist_scale;
        logic [8:0]  energy_bins_used;
        logic [6:0]  dist_bins_used;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        energy_min:       16'd1792,
        energy_max:       16'd6144,
        energy_scale:     24'd2560,
        dist_max:         32'd1000000,
        dist_scale:       32'd274878,
        energy_bins_used: 9'd170,
        dist_bins_used:   7'd64
    };

endpackage

`default_nettype wire

// ===== sv/pedh_binner.sv =====
// ----------------------------------------------------------------------------
// Bin address unit
// Scales log energy and distance by their reciprocal bin widths, registers
// the products and clamps them into a row-by-distance memory address.
// ----------------------------------------------------------------------------
`default_nettype none

module pedh_binner #(
    parameter int ENERGY_BINS = 256,
    parameter int DIST_BINS   = 64,
    localparam int AW = (ENERGY_BINS * DIST_BINS > 1) ? $clog2(ENERGY_BINS * DIST_BINS) : 1
) (
    input  wire logic           i_clk,
    input  wire logic           i_load,
    input  wire logic [15:0]    i_log_energy,
    input  wire logic [31:0]    i_distance,
    input  wire pedh_pkg::t_cfg i_cfg,
    output logic [AW-1:0]       o_addr
);
    import pedh_pkg::*;

    localparam int EIW = (ENERGY_BINS > 1) ? $clog2(ENERGY_BINS) : 1;
    localparam int DIW = (DIST_BINS > 1) ? $clog2(DIST_BINS) : 1;

    logic [15:0] e_diff;
    logic [39:0] e_prod;
    logic [63:0] d_prod;
    logic [23:0] r_eq;
    logic [31:0] r_dq;
    logic [23:0] e_lim;
    logic [31:0] d_lim;
    logic [23:0] e_clamp;
    logic [31:0] d_clamp;

    assign e_diff = i_log_energy - i_cfg.energy_min;
    assign e_prod = 40'(e_diff) * 40'(i_cfg.energy_scale);
    assign d_prod = 64'(i_distance) * 64'(i_cfg.dist_scale);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_eq <= e_prod[39:16];
            r_dq <= d_prod[63:32];
        end
    end

    always_comb begin
        if (i_cfg.energy_bins_used == '0) begin
            e_lim = 24'd1;
        end else if (24'(i_cfg.energy_bins_used) > 24'(ENERGY_BINS)) begin
            e_lim = 24'(ENERGY_BINS);
        end else begin
            e_lim = 24'(i_cfg.energy_bins_used);
        end
        if (i_cfg.dist_bins_used == '0) begin
            d_lim = 32'd1;
        end else if (32'(i_cfg.dist_bins_used) > 32'(DIST_BINS)) begin
            d_lim = 32'(DIST_BINS);
        end else begin
            d_lim = 32'(i_cfg.dist_bins_used);
        end
        e_clamp = (r_eq >= e_lim) ? (e_lim - 24'd1) : r_eq;
        d_clamp = (r_dq >= d_lim) ? (d_lim - 32'd1) : r_dq;
    end

    assign o_addr = AW'(d_clamp[DIW-1:0]) * AW'(ENERGY_BINS) + AW'(e_clamp[EIW-1:0]);

endmodule

`default_nettype wire

// ===== sv/pedh_ram.sv =====
// ----------------------------------------------------------------------------
// Count memory
// Simple dual-port synchronous memory, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pedh_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 96,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0]      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/particle_energy_distance_histogram.sv =====
// ----------------------------------------------------------------------------
// Particle energy distance histogram
// Three saturating distance-by-energy count grids (photon, electron,
// positron) kept side by side in one memory word, with record, read and
// read-and-clear words.
//
//   Channel  Dir  Handshake                  Payload
//   s_axis   in   s_axis_tvalid/tready       tuser: operation
//                                            tdata: id, log energy, distance,
//                                                   read bins
//   m_axis   out  m_axis_tvalid/tready       tuser: claimed, status
//                                            tdata: three counts
//   apb      in   psel, penable, pready      paddr, pwdata, prdata
//
// A word is in work one at a time, in this order: the accepting cycle
// feeds the multipliers, then bin address with memory read, count update with
// write back, and output load, which waits while the output is stalled.
// After reset a clearing pass zeroes all ENERGY_BINS * DIST_BINS words (16384 with
// the default sizes) while s_axis_tready stays low.
// A stalled output holds one result; one more word is taken and waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_energy_distance_histogram #(
    parameter int ENERGY_BINS = 256,
    parameter int DIST_BINS   = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // operation[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    // particle_id[31:0], log_energy[47:32], distance[79:48],
    // read_dist_bin[85:80], read_energy_bin[93:86], zero[95:94]
    input  wire logic [95:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // claimed[0], status[3:1]
    output logic [3:0]       m_axis_tuser,
    // photon_count[31:0], electron_count[63:32], positron_count[95:64]
    output logic [95:0]      m_axis_tdata,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import pedh_pkg::*;

    localparam int DEPTH = ENERGY_BINS * DIST_BINS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MW    = 3 * COUNT_WIDTH;

    t_state               r_state, n_state;
    logic [AW-1:0]        r_clr_addr;
    t_cfg                 r_cfg;
    logic                 r_is_read;
    t_status              r_status;
    logic                 r_claimed;
    logic                 r_count;
    logic                 r_clear;
    logic                 r_show;
    t_lane                r_lane;
    logic [5:0]           r_rd;
    logic [7:0]           r_re;
    logic [AW-1:0]        r_addr;
    logic [95:0]          r_res;
    logic                 r_out_valid;
    logic [95:0]          r_out_data;
    logic [3:0]           r_out_user;

    logic                 in_accept;
    logic                 cfg_write;
    logic [1:0]           in_op;
    logic [31:0]          in_id;
    logic [15:0]          in_loge;
    logic [31:0]          in_dist;
    logic [5:0]           in_rd;
    logic [7:0]           in_re;
    logic                 tracked;
    logic                 e_ok;
    logic                 d_ok;
    logic                 in_grid;
    t_status              n_status;
    t_lane                n_lane;

    logic [AW-1:0]        bin_addr;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        cur_addr;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [MW-1:0]        ram_wdata;
    logic [MW-1:0]        ram_rdata;
    logic [MW-1:0]        mod_wdata;
    logic [COUNT_WIDTH-1:0] lane_q [3];
    logic [COUNT_WIDTH-1:0] lane_d [3];
    logic [95:0]          res_data;
    logic                 out_load;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign in_op   = s_axis_tuser;
    assign in_id   = s_axis_tdata[31:0];
    assign in_loge = s_axis_tdata[47:32];
    assign in_dist = s_axis_tdata[79:48];
    assign in_rd   = s_axis_tdata[85:80];
    assign in_re   = s_axis_tdata[93:86];

    always_comb begin
        tracked = (in_id == ID_PHOTON) || (in_id == ID_ELECTRON) || (in_id == ID_POSITRON);
        e_ok    = (in_loge >= r_cfg.energy_min) && (in_loge <= r_cfg.energy_max);
        d_ok    = (in_dist <= r_cfg.dist_max);
        in_grid = (32'(in_rd) < 32'(DIST_BINS)) && (32'(in_re) < 32'(ENERGY_BINS));
        if (in_op != OP_RECORD) begin
            n_status = ST_READ_DONE;
        end else if (!tracked) begin
            n_status = ST_UNTRACKED;
        end else if (!e_ok) begin
            n_status = ST_ENERGY_RANGE;
        end else if (!d_ok) begin
            n_status = ST_TOO_FAR;
        end else begin
            n_status = ST_COUNTED;
        end
        if (in_id == ID_PHOTON) begin
            n_lane = LANE_PHOTON;
        end else if (in_id == ID_ELECTRON) begin
            n_lane = LANE_ELECTRON;
        end else begin
            n_lane = LANE_POSITRON;
        end
    end

    pedh_binner #(
        .ENERGY_BINS (ENERGY_BINS),
        .DIST_BINS   (DIST_BINS)
    ) u_binner (
        .i_clk        (i_clk),
        .i_load       (in_accept),
        .i_log_energy (in_loge),
        .i_distance   (in_dist),
        .i_cfg        (r_cfg),
        .o_addr       (bin_addr)
    );

    assign rd_addr  = AW'(r_rd) * AW'(ENERGY_BINS) + AW'(r_re);
    assign cur_addr = r_is_read ? rd_addr : bin_addr;

    pedh_ram #(
        .DEPTH (DEPTH),
        .WIDTH (MW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (cur_addr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lane_q[k] = ram_rdata[k*COUNT_WIDTH +: COUNT_WIDTH];
            lane_d[k] = lane_q[k];
        end
        if (r_count && (lane_q[r_lane] != '1)) begin
            lane_d[r_lane] = lane_q[r_lane] + COUNT_WIDTH'(1);
        end
        for (int k = 0; k < 3; k++) begin
            mod_wdata[k*COUNT_WIDTH +: COUNT_WIDTH] = r_clear ? '0 : lane_d[k];
        end
        res_data = r_show ? {32'(lane_q[2]), 32'(lane_q[1]), 32'(lane_q[0])} : '0;
    end

    always_comb begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_addr;
        ram_wdata     = mod_wdata;
        out_load      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            S_MOD: begin
                ram_we = r_count || r_clear;
            end
            S_OUT: begin
                out_load = !r_out_valid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = S_MOD;
            end
            S_MOD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_cfg       <= CFG_RESET;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_write) begin
                case (paddr[4:2])
                    REG_ENERGY_MIN:       r_cfg.energy_min       <= pwdata[15:0];
                    REG_ENERGY_MAX:       r_cfg.energy_max       <= pwdata[15:0];
                    REG_ENERGY_SCALE:     r_cfg.energy_scale     <= pwdata[23:0];
                    REG_DIST_MAX:         r_cfg.dist_max         <= pwdata;
                    REG_DIST_SCALE:       r_cfg.dist_scale       <= pwdata;
                    REG_ENERGY_BINS_USED: r_cfg.energy_bins_used <= pwdata[8:0];
                    REG_DIST_BINS_USED:   r_cfg.dist_bins_used   <= pwdata[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_is_read <= (in_op != OP_RECORD);
            r_status  <= n_status;
            r_claimed <= (in_op == OP_RECORD) && tracked;
            r_count   <= (in_op == OP_RECORD) && tracked && e_ok && d_ok;
            r_clear   <= (in_op == OP_READ_CLEAR) && in_grid;
            r_show    <= (in_op != OP_RECORD) && in_grid;
            r_lane    <= n_lane;
            r_rd      <= in_rd;
            r_re      <= in_re;
        end
        if (r_state == S_ADDR) begin
            r_addr <= cur_addr;
        end
        if (r_state == S_MOD) begin
            r_res <= res_data;
        end
        if (out_load) begin
            r_out_data <= r_res;
            r_out_user <= {r_status, r_claimed};
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_ENERGY_MIN:       prdata = 32'(r_cfg.energy_min);
            REG_ENERGY_MAX:       prdata = 32'(r_cfg.energy_max);
            REG_ENERGY_SCALE:     prdata = 32'(r_cfg.energy_scale);
            REG_DIST_MAX:         prdata = r_cfg.dist_max;
            REG_DIST_SCALE:       prdata = r_cfg.dist_scale;
            REG_ENERGY_BINS_USED: prdata = 32'(r_cfg.energy_bins_used);
            REG_DIST_BINS_USED:   prdata = 32'(r_cfg.dist_bins_used);
            default:              prdata = '0;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

`default_nettype wire

// ===== sv/pedh_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the particle energy distance histogram
// Watches the stream ports and checks ordering and result encoding.
// ----------------------------------------------------------------------------
`default_nettype none

`include "particle_energy_distance_histogram_defines.svh"

module pedh_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [3:0]  m_axis_tuser,
    input wire logic [95:0] m_axis_tdata
);
    import pedh_pkg::*;

    logic    claimed;
    t_status status;

    assign claimed = m_axis_tuser[0];
    assign status  = t_status'(m_axis_tuser[3:1]);

    `PEDH_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `PEDH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `PEDH_ASSERT_SAME(a_record_no_counts, i_clk, i_rst_n, m_axis_tvalid && (status != ST_READ_DONE), m_axis_tdata == '0)
    `PEDH_ASSERT_SAME(a_claimed_code, i_clk, i_rst_n, m_axis_tvalid, claimed == ((status == ST_COUNTED) || (status == ST_ENERGY_RANGE) || (status == ST_TOO_FAR)))

endmodule

bind particle_energy_distance_histogram pedh_checker u_pedh_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
